FILE: design/bsfe_pkg.sv
// shared types and constants for the binned step function evaluator
// no dependencies; imported by every module of the block
`default_nettype none

package bsfe_pkg;

  localparam int MaxBinsDefault = 16;
  localparam int ValW           = 32;
  localparam int ReqW           = 2;
  localparam int IdxW           = 5;
  localparam int NumBinsW       = 5;
  localparam int CfgIdxW        = 1;
  localparam int CfgDataW       = 5;
  localparam int DivSteps       = 32;
  localparam int DivCntW        = 5;

  typedef enum logic [ReqW-1:0] {
    REQ_EVAL   = 2'd0,
    REQ_WR_BND = 2'd1,
    REQ_WR_HGT = 2'd2
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NUM_BINS = 1'b0,
    CFG_INTERP   = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_B_ADDR,
    ST_B_DATA,
    ST_H_ADDR,
    ST_H_DATA,
    ST_LERP,
    ST_DONE
  } ctrl_st_e;

  typedef enum logic [1:0] {
    LP_IDLE,
    LP_MUL,
    LP_DIV,
    LP_FIN
  } lerp_st_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic b_read;
    logic b_scan;
    logic h_read;
    logic lerp_start;
    logic out_load;
  } bsfe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic interp;
    logic hit;
    logic lerp_done;
  } bsfe_sts_t;

endpackage

`default_nettype wire

FILE: design/bsfe_lerp.sv
// linear interpolation unit: one 32x32 multiply, then a restoring divide
// one quotient bit per cycle; depends on bsfe_pkg
`default_nettype none

module bsfe_lerp
  import bsfe_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [ValW-1:0] x_i,
  input  logic signed [ValW-1:0] c0_i,
  input  logic signed [ValW-1:0] c1_i,
  input  logic signed [ValW-1:0] y0_i,
  input  logic signed [ValW-1:0] y1_i,
  output logic                   done_o,
  output logic signed [ValW-1:0] result_o
);

  lerp_st_e st_q, st_d;
  logic [DivCntW-1:0] cnt_q;

  logic [ValW:0] dx_full, span_full, dy_full, dy_neg;
  logic [ValW-1:0] dx_q, span_q, mag_q, rem_q, quo_q;
  logic neg_q;
  logic signed [ValW-1:0] y0_q;
  logic [2*ValW-1:0] prod;
  logic [ValW:0] trial, diff;
  logic ge;
  logic [ValW+1:0] y0_ext, q_ext, sum;

  // differences are exact in 33 bits; dx and span are positive and below 2^32
  assign dx_full   = {x_i[ValW-1], x_i} - {c0_i[ValW-1], c0_i};
  assign span_full = {c1_i[ValW-1], c1_i} - {c0_i[ValW-1], c0_i};
  assign dy_full   = {y1_i[ValW-1], y1_i} - {y0_i[ValW-1], y0_i};
  assign dy_neg    = ~dy_full + 1'b1;

  assign prod  = mag_q * dx_q;
  assign trial = {rem_q, quo_q[ValW-1]};
  assign ge    = trial >= {1'b0, span_q};
  assign diff  = trial - {1'b0, span_q};

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      LP_IDLE: if (start_i) st_d = LP_MUL;
      LP_MUL:  st_d = LP_DIV;
      LP_DIV:  if (cnt_q == '0) st_d = LP_FIN;
      LP_FIN:  st_d = LP_IDLE;
      default: st_d = LP_IDLE;
    endcase
  end

  always_comb begin
    done_o = (st_q == LP_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= LP_IDLE;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == LP_MUL) cnt_q <= DivCntW'(DivSteps - 1);
      else if (st_q == LP_DIV) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == LP_IDLE && start_i) begin
      dx_q   <= dx_full[ValW-1:0];
      span_q <= span_full[ValW-1:0];
      mag_q  <= dy_full[ValW] ? dy_neg[ValW-1:0] : dy_full[ValW-1:0];
      neg_q  <= dy_full[ValW];
      y0_q   <= y0_i;
    end
    if (st_q == LP_MUL) begin
      // upper half is below span because the quotient stays below 2^32
      rem_q <= prod[2*ValW-1:ValW];
      quo_q <= prod[ValW-1:0];
    end
    if (st_q == LP_DIV) begin
      rem_q <= ge ? diff[ValW-1:0] : trial[ValW-1:0];
      quo_q <= {quo_q[ValW-2:0], ge};
    end
  end

  assign y0_ext = {{2{y0_q[ValW-1]}}, y0_q};
  assign q_ext  = {2'b00, quo_q};
  assign sum    = neg_q ? (y0_ext - q_ext) : (y0_ext + q_ext);

  always_comb begin
    if (!sum[ValW+1] && sum[ValW:ValW-1] != 2'b00) begin
      result_o = {1'b0, {(ValW-1){1'b1}}};
    end else if (sum[ValW+1] && sum[ValW:ValW-1] != 2'b11) begin
      result_o = {1'b1, {(ValW-1){1'b0}}};
    end else begin
      result_o = sum[ValW-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/bsfe_dp.sv
// datapath: config registers, boundary and height memories, bin scan,
// interpolation unit and output register; depends on bsfe_pkg, bsfe_lerp
`default_nettype none

module bsfe_dp
  import bsfe_pkg::*;
#(
  parameter int MAX_BINS = MaxBinsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_acc_i,
  input  logic [ReqW-1:0]        req_type_i,
  input  logic [IdxW-1:0]        entry_index_i,
  input  logic signed [ValW-1:0] value_in_i,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  input  bsfe_cmd_t              cmd_i,
  output bsfe_sts_t              sts_o,
  output logic signed [ValW-1:0] func_value_o
);

  localparam int NW  = $clog2(MAX_BINS + 1);
  localparam int HAW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  logic [NumBinsW-1:0] num_bins_q;
  logic                interp_cfg_q;
  logic [31:0]         nb_w, idx_w;
  logic [NW-1:0]       n_eff;

  logic [ValW-1:0] bnd_mem [MAX_BINS+1];
  logic [ValW-1:0] hgt_mem [MAX_BINS];
  logic            wr_bnd, wr_hgt;
  logic [NW-1:0]   b_waddr;
  logic [HAW-1:0]  h_waddr, ha0, ha1;

  logic signed [ValW-1:0] b_rdata_q, h0_rdata_q, h1_rdata_q;
  logic signed [ValW-1:0] x_q, pb_q, pc_q, b0_q, bn_q, c0_q, c1_q;
  logic [NW-1:0]          n_q, k_q, seg_q, seg_m1;
  logic                   interp_q, found_q;

  logic [ValW:0]          pair_sum;
  logic signed [ValW-1:0] mid, lo, hi, y0, y1, lerp_res;
  logic                   hit_lo, hit_hi, in_range, lerp_done;

  always_comb begin
    nb_w = 32'(num_bins_q);
    if (nb_w == 32'd0) n_eff = NW'(1);
    else if (nb_w > 32'(MAX_BINS)) n_eff = NW'(MAX_BINS);
    else n_eff = nb_w[NW-1:0];
  end

  assign idx_w   = 32'(entry_index_i);
  assign wr_bnd  = in_acc_i && (req_type_i == REQ_WR_BND) && (idx_w <= 32'(MAX_BINS));
  assign wr_hgt  = in_acc_i && (req_type_i == REQ_WR_HGT) && (idx_w < 32'(MAX_BINS));
  assign b_waddr = idx_w[NW-1:0];
  assign h_waddr = idx_w[HAW-1:0];

  // heights for the segment ends
  assign seg_m1 = seg_q - NW'(1);
  assign ha0    = (seg_q != '0) ? seg_m1[HAW-1:0] : '0;
  assign ha1    = (32'(seg_q) < 32'(MAX_BINS)) ? seg_q[HAW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (wr_bnd) bnd_mem[b_waddr] <= value_in_i;
    if (cmd_i.b_read) b_rdata_q <= bnd_mem[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_hgt) hgt_mem[h_waddr] <= value_in_i;
    if (cmd_i.h_read) begin
      h0_rdata_q <= hgt_mem[ha0];
      h1_rdata_q <= hgt_mem[ha1];
    end
  end

  // floor of the mean of two neighbor boundaries
  assign pair_sum = {pb_q[ValW-1], pb_q} + {b_rdata_q[ValW-1], b_rdata_q};
  assign mid      = pair_sum[ValW:1];
  assign lo       = interp_q ? pc_q : pb_q;
  assign hi       = interp_q ? mid : b_rdata_q;
  assign hit_lo   = !found_q && (k_q != '0) && (x_q > lo) && (x_q <= hi);
  // last knot segment, from the last center to the last boundary
  assign hit_hi   = !found_q && interp_q && (k_q == n_q) && (x_q > mid) &&
                    (x_q <= b_rdata_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bins_q   <= NumBinsW'(1);
      interp_cfg_q <= 1'b0;
      k_q          <= '0;
      found_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_NUM_BINS: num_bins_q <= cfg_data_i[NumBinsW-1:0];
          CFG_INTERP:   interp_cfg_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.start) begin
        k_q     <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.b_scan) begin
        k_q <= k_q + NW'(1);
        if (hit_lo || hit_hi) found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q      <= value_in_i;
      n_q      <= n_eff;
      interp_q <= interp_cfg_q;
    end
    if (cmd_i.b_scan) begin
      pb_q <= b_rdata_q;
      if (k_q == '0) begin
        b0_q <= b_rdata_q;
        pc_q <= b_rdata_q;
      end else begin
        pc_q <= mid;
        if (hit_lo) begin
          seg_q <= k_q - NW'(1);
          c0_q  <= lo;
          c1_q  <= hi;
        end else if (hit_hi) begin
          seg_q <= k_q;
          c0_q  <= mid;
          c1_q  <= b_rdata_q;
        end
      end
      if (k_q == n_q) bn_q <= b_rdata_q;
    end
  end

  assign in_range = !(x_q < b0_q) && !(x_q > bn_q);
  assign y0       = (seg_q == '0) ? '0 : h0_rdata_q;
  assign y1       = (seg_q == n_q) ? '0 : h1_rdata_q;

  bsfe_lerp u_lerp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.lerp_start),
    .x_i      (x_q),
    .c0_i     (c0_q),
    .c1_i     (c1_q),
    .y0_i     (y0),
    .y1_i     (y1),
    .done_o   (lerp_done),
    .result_o (lerp_res)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (!(found_q && in_range)) func_value_o <= '0;
      else if (interp_q) func_value_o <= lerp_res;
      else func_value_o <= h1_rdata_q;
    end
  end

  always_comb begin
    sts_o.scan_last = (k_q == n_q);
    sts_o.interp    = interp_q;
    sts_o.hit       = found_q && in_range;
    sts_o.lerp_done = lerp_done;
  end

endmodule

`default_nettype wire

FILE: design/bsfe_ctrl.sv
// controller state machine: sequences the scan, height read, interpolation
// and result beat; depends on bsfe_pkg
`default_nettype none

module bsfe_ctrl
  import bsfe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      eval_acc_i,
  input  logic      out_stall_i,
  input  bsfe_sts_t sts_i,
  output bsfe_cmd_t cmd_o,
  output logic      in_stall_o,
  output logic      out_valid_o
);

  ctrl_st_e st_q, st_d;
  logic     out_valid_q, out_valid_d;
  logic     out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:   if (eval_acc_i) st_d = ST_B_ADDR;
      ST_B_ADDR: st_d = ST_B_DATA;
      ST_B_DATA: st_d = sts_i.scan_last ? ST_H_ADDR : ST_B_ADDR;
      ST_H_ADDR: st_d = ST_H_DATA;
      ST_H_DATA: st_d = (sts_i.interp && sts_i.hit) ? ST_LERP : ST_DONE;
      ST_LERP:   if (sts_i.lerp_done) st_d = ST_DONE;
      ST_DONE:   if (out_free) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.start      = (st_q == ST_IDLE) && eval_acc_i;
    cmd_o.b_read     = (st_q == ST_B_ADDR);
    cmd_o.b_scan     = (st_q == ST_B_DATA);
    cmd_o.h_read     = (st_q == ST_H_ADDR);
    cmd_o.lerp_start = (st_q == ST_H_DATA) && sts_i.interp && sts_i.hit;
    cmd_o.out_load   = (st_q == ST_DONE) && out_free;
    in_stall_o       = (st_q != ST_IDLE);
    out_valid_d      = cmd_o.out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: design/binned_step_function_eval_top.sv
// Binned step function evaluator, top level.
// Input channel (in_valid_i / in_stall_o) carries one beat per request:
// req_type_i selects evaluate at value_in_i, write boundary entry, or
// write bin height entry (entry_index_i). Writes take effect in the beat's
// cycle and return nothing; an unused request type is dropped.
// Output channel (out_valid_o / out_stall_i) returns one func_value_o beat
// per evaluate, Q16.16, zero outside the first and last boundary.
// Config port: cfg_we_i writes num_bins (index 0) or interpolate_mode
// (index 1) from cfg_data_i; write only while no evaluate is in flight.
// Sequence, n = bins in use: the boundary scan reads entries 0 to n, one
// per pass through a read-address and a data state; the heights are then
// read; in interpolate mode, when x lands in a segment, a multiply, a
// restoring divide and a finish step follow before out_valid_o rises.
// One evaluate is in flight at a time; in_stall_o is high while it runs and
// drops as the result loads, so the next evaluate waits for that load.
// Write beats are taken every cycle while idle, even with a result waiting.
// A stalled result holds in the output register; the next evaluate is
// accepted but finishes only once that register drains.
// Reset (rst_ni, async, active low) sets num_bins to 1, step mode, and
// clears control state; table contents are undefined until written.
`default_nettype none

module binned_step_function_eval_top
  import bsfe_pkg::*;
#(
  parameter int MAX_BINS = MaxBinsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [ReqW-1:0]        req_type_i,
  input  logic [IdxW-1:0]        entry_index_i,
  input  logic signed [ValW-1:0] value_in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [ValW-1:0] func_value_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i
);

  bsfe_cmd_t cmd;
  bsfe_sts_t sts;
  logic      in_acc;
  logic      eval_acc;

  // beat accepted on the input side
  assign in_acc   = in_valid_i && !in_stall_o;
  assign eval_acc = in_acc && (req_type_i == REQ_EVAL);

  bsfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eval_acc_i  (eval_acc),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  bsfe_dp #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_acc_i      (in_acc),
    .req_type_i    (req_type_i),
    .entry_index_i (entry_index_i),
    .value_in_i    (value_in_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_value_o  (func_value_o)
  );

  // an accepted evaluate always starts a run
  a_eval_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && req_type_i == REQ_EVAL) |=> in_stall_o)
    else $error("evaluate beat did not start a run");

  // write beats never occupy the sequencer
  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && req_type_i != REQ_EVAL) |=> !in_stall_o)
    else $error("write beat left the block busy");

  // a new result only comes out of a running evaluate
  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an evaluate in flight");

  // a run ends by loading its result
  a_run_ends_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("run finished without a result");

endmodule

`default_nettype wire
